// ----- hdl/rgbu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_pkg
// Shared types, widths and the channel-mean helper for the 2x RGBA upscaler.
// ----------------------------------------------------------------------------
package rgbu_pkg;

  localparam int PIX_W        = 32;   // four 8-bit channels
  localparam int COORD_W      = 10;   // cell column / row on the result
  localparam int CFG_W        = 11;   // source_side register
  localparam int MAX_SIDE_DEF = 1024;
  localparam int RESET_SIDE   = 256;
  localparam int MIN_SIDE     = 2;
  localparam int NUM_BLK      = 4;    // blocks one item can cause

  // Block kinds, in output order; also bit positions in a pending mask.
  typedef enum logic [1:0] {
    BLK_MAIN   = 2'd0,   // cell up-left of the new pixel
    BLK_EDGE   = 2'd1,   // last-column cell of the row above
    BLK_BOTTOM = 2'd2,   // last-row cell left of the new pixel
    BLK_CORNER = 2'd3    // bottom-right cell of the frame
  } blk_t;

  typedef logic [PIX_W-1:0] pix_t;

  // Item handed from the fetch stage to the block emitter.
  typedef struct packed {
    logic [NUM_BLK-1:0] pending;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pix_t               cur;
    pix_t               left;
    pix_t               up_l;
    pix_t               up_r;
  } rgbu_item_t;

  // Per-channel floor((a + b) / 2); no carry crosses a channel.
  function automatic pix_t chan_mean(input pix_t a, input pix_t b);
    chan_mean = (a & b) + (((a ^ b) & 32'hFEFE_FEFE) >> 1);
  endfunction

endpackage

// ----- hdl/rgbu_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_in_if / rgbu_out_if
// Valid/ready channels: source pixels in, 2x2 output blocks out.
// ----------------------------------------------------------------------------
interface rgbu_in_if import rgbu_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface rgbu_out_if import rgbu_pkg::*; ();
  logic valid;
  logic ready;
  logic [COORD_W-1:0] cell_column;
  logic [COORD_W-1:0] cell_row;
  logic [PIX_W-1:0]   upper_left;
  logic [PIX_W-1:0]   upper_right;
  logic [PIX_W-1:0]   lower_left;
  logic [PIX_W-1:0]   lower_right;
  logic               last_of_item;
  logic               last_of_frame;

  modport source (output valid, output cell_column, output cell_row,
                  output upper_left, output upper_right, output lower_left,
                  output lower_right, output last_of_item, output last_of_frame,
                  input ready);
  modport sink   (input valid, input cell_column, input cell_row,
                  input upper_left, input upper_right, input lower_left,
                  input lower_right, input last_of_item, input last_of_frame,
                  output ready);
endinterface

// ----- hdl/rgbu_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module rgbu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/rgbu_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbu_emit
// Holds one item, builds its pending 2x2 blocks one per cycle while out_ch
// is not stalled, and drives the output register.
// ----------------------------------------------------------------------------
module rgbu_emit import rgbu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  rgbu_item_t         item,
  output logic               free,
  rgbu_out_if.source         out_ch
);

  rgbu_item_t         item_r;
  logic [NUM_BLK-1:0] pend_r, pend_nxt;
  blk_t               sel;
  logic [NUM_BLK-1:0] sel_oh, rest;
  logic               emit;

  pix_t p00, p10, p01, p11, tr, bl, br;
  logic [COORD_W-1:0] col, row;

  logic               ov_r, ov_nxt;
  logic [COORD_W-1:0] o_col_r, o_row_r;
  pix_t               o_ul_r, o_ur_r, o_ll_r, o_lr_r;
  logic               o_lit_r, o_lof_r;

  // lowest pending block goes first
  always_comb begin
    if (pend_r[BLK_MAIN]) begin
      sel = BLK_MAIN;
    end else if (pend_r[BLK_EDGE]) begin
      sel = BLK_EDGE;
    end else if (pend_r[BLK_BOTTOM]) begin
      sel = BLK_BOTTOM;
    end else begin
      sel = BLK_CORNER;
    end
  end

  assign sel_oh = NUM_BLK'(1) << sel;
  assign rest   = pend_r & ~sel_oh;
  assign emit   = (|pend_r) && (!ov_r || out_ch.ready);
  assign free   = (pend_r == '0) || (emit && rest == '0);

  always_comb begin
    case (sel)
      BLK_MAIN: begin
        p00 = item_r.up_l; p10 = item_r.up_r; p01 = item_r.left; p11 = item_r.cur;
        col = item_r.col - COORD_W'(1);
        row = item_r.row - COORD_W'(1);
      end
      BLK_EDGE: begin
        p00 = item_r.up_r; p10 = item_r.up_r; p01 = item_r.cur; p11 = item_r.cur;
        col = item_r.col;
        row = item_r.row - COORD_W'(1);
      end
      BLK_BOTTOM: begin
        p00 = item_r.left; p10 = item_r.cur; p01 = item_r.left; p11 = item_r.cur;
        col = item_r.col - COORD_W'(1);
        row = item_r.row;
      end
      BLK_CORNER: begin
        p00 = item_r.cur; p10 = item_r.cur; p01 = item_r.cur; p11 = item_r.cur;
        col = item_r.col;
        row = item_r.row;
      end
      default: begin
        p00 = item_r.cur; p10 = item_r.cur; p01 = item_r.cur; p11 = item_r.cur;
        col = item_r.col;
        row = item_r.row;
      end
    endcase
  end

  assign tr = chan_mean(p00, p10);
  assign bl = chan_mean(p00, p01);
  assign br = chan_mean(chan_mean(tr, chan_mean(p01, p11)),
                        chan_mean(bl, chan_mean(p10, p11)));

  always_comb begin
    if (load) begin
      pend_nxt = item.pending;
    end else if (emit) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_comb begin
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
    if (emit) begin
      o_col_r <= col;
      o_row_r <= row;
      o_ul_r  <= p00;
      o_ur_r  <= tr;
      o_ll_r  <= bl;
      o_lr_r  <= br;
      o_lit_r <= (rest == '0);
      o_lof_r <= (sel == BLK_CORNER);
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.cell_column   = o_col_r;
  assign out_ch.cell_row      = o_row_r;
  assign out_ch.upper_left    = o_ul_r;
  assign out_ch.upper_right   = o_ur_r;
  assign out_ch.lower_left    = o_ll_r;
  assign out_ch.lower_right   = o_lr_r;
  assign out_ch.last_of_item  = o_lit_r;
  assign out_ch.last_of_frame = o_lof_r;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("emitter loaded while blocks still pending");

  a_frame_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_lof_r) |-> o_lit_r)
    else $error("frame-end block not flagged as last of item");

  a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
    ((|pend_r) && !ov_r) |=> ov_r)
    else $error("pending block not moved to empty output register");
`endif

endmodule

// ----- hdl/rgba_2x_interpolating_upscaler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_2x_interpolating_upscaler_unit
// 2x interpolating upscaler for a square RGBA image fed in raster order;
// emits one 2x2 output block per source cell, edges replicated.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+---------------------------------------
//   in_ch    | in  | valid/ready       | source_pixel (32b, ch0 in low byte)
//   out_ch   | out | valid/ready       | cell_column, cell_row, four pixels,
//            |     |                   | last_of_item, last_of_frame
//   cfg_*    | in  | write enable only | source_side (11b), restarts frame
//
// Path: an item's first block reaches out_ch through the fetch stage (with
// line-buffer read), then the emitter, whose block math feeds the output
// register.
// Rate: one item per cycle while each item causes at most one block and
// out_ch does not stall; an item causing more blocks (row end, last row,
// frame end) holds the block emitter, which builds one block per cycle.
// Reset (rst_n low, synchronous) clears counters, valids and left pixel and
// sets the side to 256; the line buffer is not cleared.
// A stalled out_ch backs up through the emitter and fetch stage to in_ch.
//
module rgba_2x_interpolating_upscaler_unit import rgbu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rgbu_in_if.sink          in_ch,
  rgbu_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int ResetSideM1 = ((RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE) - 1;

  // Frame position and side
  logic [CW-1:0] side_m1_r, side_m1_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [CW-1:0] row_cnt_r, row_cnt_nxt;
  logic [31:0]   cfg_ext;
  logic          last_col, last_row, accept;
  logic [NUM_BLK-1:0] pend_new;

  pix_t left_pixel_r;

  // Fetch stage: item waits here for the line-buffer read
  logic               s1_valid_r, s1_valid_nxt;
  logic [NUM_BLK-1:0] s1_pend_r;
  logic [COORD_W-1:0] s1_col_r, s1_row_r;
  pix_t               s1_cur_r, s1_left_r;
  logic               s1_last_col_r;
  logic               s1_adv;

  // up_hold_r: pixel above the previous item; edge_r: last-column pixel of
  // the previous row (the last column never goes to the RAM)
  pix_t up_hold_r, edge_r, up_r, ram_rdata;

  logic          ram_we, ram_re;
  logic [CW-1:0] ram_waddr, ram_raddr;

  rgbu_item_t emit_item;
  logic       emit_free, emit_load;

  // --- side register, clamped to 2 .. MAX_SIDE on write ---
  assign cfg_ext = 32'(cfg_wdata);

  always_comb begin
    if (!cfg_we) begin
      side_m1_nxt = side_m1_r;
    end else if (cfg_ext < 32'(MIN_SIDE)) begin
      side_m1_nxt = CW'(MIN_SIDE - 1);
    end else if (cfg_ext > 32'(MAX_SIDE)) begin
      side_m1_nxt = CW'(MAX_SIDE - 1);
    end else begin
      side_m1_nxt = CW'(cfg_ext - 32'd1);
    end
  end

  // --- input side ---
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_col    = col_cnt_r >= side_m1_r;
  assign last_row    = row_cnt_r >= side_m1_r;

  // blocks this pixel completes, in output order
  always_comb begin
    pend_new             = '0;
    pend_new[BLK_MAIN]   = (row_cnt_r != '0) && (col_cnt_r != '0);
    pend_new[BLK_EDGE]   = (row_cnt_r != '0) && (col_cnt_r != '0) && last_col;
    pend_new[BLK_BOTTOM] = last_row && (col_cnt_r != '0);
    pend_new[BLK_CORNER] = last_row && (col_cnt_r != '0) && last_col;
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_we) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + CW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  // --- line buffer: entry c-1 gets the left pixel, entry c is read ---
  assign ram_we    = accept && (col_cnt_r != '0);
  assign ram_waddr = col_cnt_r - CW'(1);
  assign ram_re    = accept;
  assign ram_raddr = col_cnt_r;

  rgbu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SIDE)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (left_pixel_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --- fetch stage ---
  assign up_r   = s1_last_col_r ? edge_r : ram_rdata;
  assign s1_adv = s1_valid_r && ((s1_pend_r == '0) || emit_free);

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_m1_r    <= CW'(ResetSideM1);
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      left_pixel_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      side_m1_r  <= side_m1_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        left_pixel_r <= in_ch.source_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pend_r     <= pend_new;
      s1_col_r      <= COORD_W'(col_cnt_r);
      s1_row_r      <= COORD_W'(row_cnt_r);
      s1_cur_r      <= in_ch.source_pixel;
      s1_left_r     <= left_pixel_r;
      s1_last_col_r <= last_col;
    end
    if (s1_adv) begin
      up_hold_r <= up_r;
      if (s1_last_col_r) begin
        edge_r <= s1_cur_r;
      end
    end
  end

  // --- block emitter and output register ---
  assign emit_load = s1_adv && (s1_pend_r != '0);

  always_comb begin
    emit_item.pending = s1_pend_r;
    emit_item.col     = s1_col_r;
    emit_item.row     = s1_row_r;
    emit_item.cur     = s1_cur_r;
    emit_item.left    = s1_left_r;
    emit_item.up_l    = up_hold_r;
    emit_item.up_r    = up_r;
  end

  rgbu_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (emit_load),
    .item   (emit_item),
    .free   (emit_free),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_cnt_r <= side_m1_r) && (row_cnt_r <= side_m1_r))
    else $error("frame counter beyond configured side");

  a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line buffer read and write at the same entry");

  a_edge_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_pend_r[BLK_EDGE]) |-> s1_pend_r[BLK_MAIN])
    else $error("edge block without its main block");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (col_cnt_r == '0) && (row_cnt_r == '0) && (side_m1_r != '0))
    else $error("side write did not restart the frame");
`endif

endmodule
